// ===== design/ifp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifp_pkg: shared types and constants for the IMU frame parser
// Frame layout, type codes, scale factors, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
    localparam int SCALE_W     = 11;
    localparam int VALUE_W     = 27;
    localparam int WORD_BYTES  = 6;   // three 16-bit words, bytes 2..7

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] KIND_RATE   = 8'h52;
    localparam logic [7:0] KIND_ANGLE  = 8'h53;
    localparam logic [7:0] KIND_LOW    = 8'h50;
    localparam logic [7:0] KIND_HIGH   = 8'h5A;

    localparam logic [SCALE_W-1:0] SCALE_RATE  = SCALE_W'(2000);
    localparam logic [SCALE_W-1:0] SCALE_ANGLE = SCALE_W'(180);

    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_RESYNC = 1'b1;

    typedef enum logic [1:0] {
        STATUS_RATE  = 2'd0,
        STATUS_ANGLE = 2'd1,
        STATUS_OTHER = 2'd2,
        STATUS_ERROR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_EMIT_GOOD,
        ST_EMIT_BAD,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

endpackage

// ===== design/ifp_store.sv =====
// ----------------------------------------------------------------------------
// ifp_store: frame byte store
// Eleven-entry byte memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ifp_store import ifp_pkg::*; (
    input  logic             aclk,
    input  store_wr_t        wr,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [FRAME_BYTES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        // reads past the last entry are don't-care
        if (rd_addr < IDX_W'(FRAME_BYTES)) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/ifp_scaler.sv =====
// ----------------------------------------------------------------------------
// ifp_scaler: shared word scaler
// Signed 16-bit word times unsigned scale, one product per cycle, registered.
// ----------------------------------------------------------------------------
module ifp_scaler import ifp_pkg::*; (
    input  logic                      aclk,
    input  logic signed [15:0]        word,
    input  logic        [SCALE_W-1:0] scale,
    output logic signed [VALUE_W-1:0] product
);

    logic signed [16+SCALE_W:0] full;
    logic signed [VALUE_W-1:0]  product_reg;

    assign full    = word * signed'({1'b0, scale});
    assign product = product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= signed'(full[VALUE_W-1:0]);
    end

endmodule

// ===== design/imu_frame_parser_resync_core.sv =====
// ----------------------------------------------------------------------------
// imu_frame_parser_resync_core: serial sensor frame parser with resync
// Collects 11-byte frames, checks the sum byte, scales rate and angle words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one word per received serial byte, or a resync word
//   (s_action = 1) that drops any partial frame. s_end_of_burst is carried
//   for the sender's bookkeeping and does not change parsing.
//   Output channel (m_*): one word per completed frame, either a good frame
//   (status 0/1/2, scaled words) or a checksum error (status 3, zero words),
//   with the running good/bad frame counts after that frame.
// Timing:
//   A byte that does not complete a frame is taken in idle. The byte that
//   completes a frame starts a pass over the byte store: sum and scan the
//   eleven bytes through the single read port, then run the three words
//   through the shared multiplier for a good frame, then post the result.
//   A bad frame posts its result, then, if a header byte was found after
//   byte 0, copies the kept bytes from it down to the front. s_ready is
//   low for the whole pass.
// Stall:
//   A posted result sits in the output register until taken; bytes keep
//   flowing meanwhile. The next frame result waits until that register frees.
// Reset:
//   aresetn (sync, active low) returns to idle, empties the parse position, zeroes counts and clears m_valid.
// ----------------------------------------------------------------------------
module imu_frame_parser_resync_core import ifp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // received bytes
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [7:0]                s_rx_byte,
    input  logic                      s_end_of_burst,
    // frame results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [6:0]                m_frame_kind,
    output logic signed [VALUE_W-1:0] m_value_x,
    output logic signed [VALUE_W-1:0] m_value_y,
    output logic signed [VALUE_W-1:0] m_value_z,
    output logic [31:0]               m_good_count,
    output logic [31:0]               m_bad_count
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         kind_reg, kind_next;
    logic [7:0]         byte_reg [WORD_BYTES];
    logic [7:0]         byte_next [WORD_BYTES];
    logic               hdr_found_reg, hdr_found_next;
    logic [IDX_W-1:0]   hdr_pos_reg, hdr_pos_next;
    logic [1:0]         mul_cnt_reg, mul_cnt_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    status_t            status_reg, status_next;
    logic signed [VALUE_W-1:0] val_reg [3];
    logic signed [VALUE_W-1:0] val_next [3];
    logic [31:0]        good_reg, good_next;
    logic [31:0]        bad_reg, bad_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [6:0]         m_kind_reg, m_kind_next;
    logic signed [VALUE_W-1:0] m_x_reg, m_x_next;
    logic signed [VALUE_W-1:0] m_y_reg, m_y_next;
    logic signed [VALUE_W-1:0] m_z_reg, m_z_next;

    store_wr_t          store_wr;
    logic [IDX_W-1:0]   rd_addr;
    logic [7:0]         rd_data;
    logic signed [15:0] mul_word;
    logic signed [VALUE_W-1:0] product;

    logic [IDX_W-1:0]   pidx;
    logic [IDX_W-1:0]   keep;
    logic               out_free;

    ifp_store u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ifp_scaler u_scaler (
        .aclk    (aclk),
        .word    (mul_word),
        .scale   (scale_reg),
        .product (product)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_frame_kind = m_kind_reg;
    assign m_value_x    = m_x_reg;
    assign m_value_y    = m_y_reg;
    assign m_value_z    = m_z_reg;
    // counts only move when a new result is posted, so they track the output
    assign m_good_count = good_reg;
    assign m_bad_count  = bad_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign pidx     = cnt_reg - IDX_W'(1);             // byte index of rd_data in ST_SUM, write index in ST_SHIFT
    assign keep     = IDX_W'(FRAME_BYTES) - hdr_pos_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        hdr_found_next = hdr_found_reg;
        hdr_pos_next   = hdr_pos_reg;
        mul_cnt_next   = mul_cnt_reg;
        scale_next     = scale_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_kind_next    = m_kind_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_z_next       = m_z_reg;
        store_wr       = '0;
        rd_addr        = cnt_reg;
        mul_word       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_RESYNC) begin
                        fill_next = '0;
                    end else if (fill_reg == '0) begin
                        // hunting for a header
                        if (s_rx_byte == HEADER_BYTE) begin
                            store_wr  = '{en: 1'b1, addr: '0, data: s_rx_byte};
                            fill_next = IDX_W'(1);
                        end
                    end else begin
                        store_wr  = '{en: 1'b1, addr: fill_reg, data: s_rx_byte};
                        fill_next = fill_reg + IDX_W'(1);
                        if (fill_reg == IDX_W'(1) &&
                            (s_rx_byte < KIND_LOW || s_rx_byte > KIND_HIGH)) begin
                            // bad type: drop the partial frame; a header byte is never a bad type
                            fill_next = (s_rx_byte == HEADER_BYTE) ? IDX_W'(1) : '0;
                        end else if (fill_reg == IDX_W'(FRAME_BYTES - 1)) begin
                            state_next     = ST_SUM;
                            cnt_next       = '0;
                            sum_next       = '0;
                            hdr_found_next = 1'b0;
                        end
                    end
                end
            end

            ST_SUM: begin
                // read byte cnt, process byte cnt-1 (registered read)
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg != '0) begin
                    if (pidx < IDX_W'(FRAME_BYTES - 1)) begin
                        sum_next = sum_reg + rd_data;
                    end
                    if (pidx == IDX_W'(1)) begin
                        kind_next = rd_data;
                    end
                    if (pidx >= IDX_W'(2) && pidx <= IDX_W'(WORD_BYTES + 1)) begin
                        byte_next[3'(pidx - IDX_W'(2))] = rd_data;
                    end
                    if (pidx != '0 && rd_data == HEADER_BYTE && !hdr_found_reg) begin
                        // pidx is at least 1 here, byte 0 is never scanned
                        hdr_found_next = 1'b1;
                        hdr_pos_next   = pidx;
                    end
                    if (pidx == IDX_W'(FRAME_BYTES - 1)) begin
                        if (sum_reg == rd_data) begin
                            state_next   = ST_MUL;
                            mul_cnt_next = '0;
                            if (kind_reg == KIND_RATE) begin
                                scale_next  = SCALE_RATE;
                                status_next = STATUS_RATE;
                            end else if (kind_reg == KIND_ANGLE) begin
                                scale_next  = SCALE_ANGLE;
                                status_next = STATUS_ANGLE;
                            end else begin
                                scale_next  = '0;
                                status_next = STATUS_OTHER;
                            end
                        end else begin
                            state_next = ST_EMIT_BAD;
                        end
                    end
                end
            end

            ST_MUL: begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                unique case (mul_cnt_reg)
                    2'd0: mul_word = signed'({byte_reg[1], byte_reg[0]});
                    2'd1: begin
                        mul_word    = signed'({byte_reg[3], byte_reg[2]});
                        val_next[0] = product;
                    end
                    2'd2: begin
                        mul_word    = signed'({byte_reg[5], byte_reg[4]});
                        val_next[1] = product;
                    end
                    default: begin
                        val_next[2] = product;
                        state_next  = ST_EMIT_GOOD;
                    end
                endcase
            end

            ST_EMIT_GOOD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_kind_next   = kind_reg[6:0];
                    m_x_next      = val_reg[0];
                    m_y_next      = val_reg[1];
                    m_z_next      = val_reg[2];
                    good_next     = good_reg + 32'd1;
                    fill_next     = '0;
                    state_next    = ST_IDLE;
                end
            end

            ST_EMIT_BAD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_ERROR;
                    m_kind_next   = kind_reg[6:0];
                    m_x_next      = '0;
                    m_y_next      = '0;
                    m_z_next      = '0;
                    bad_next      = bad_reg + 32'd1;
                    if (hdr_found_reg) begin
                        state_next = ST_SHIFT;
                        cnt_next   = '0;
                    end else begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SHIFT: begin
                // copy bytes hdr_pos.. down to 0..; the write trails the registered read
                rd_addr = hdr_pos_reg + cnt_reg;
                if (cnt_reg != '0) begin
                    store_wr = '{en: 1'b1, addr: pidx, data: rd_data};
                end
                if (cnt_reg == keep) begin
                    fill_next  = keep;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        sum_reg       <= sum_next;
        kind_reg      <= kind_next;
        byte_reg      <= byte_next;
        hdr_found_reg <= hdr_found_next;
        hdr_pos_reg   <= hdr_pos_next;
        mul_cnt_reg   <= mul_cnt_next;
        scale_reg     <= scale_next;
        status_reg    <= status_next;
        val_reg       <= val_next;
        m_status_reg  <= m_status_next;
        m_kind_reg    <= m_kind_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_z_reg       <= m_z_next;
    end

endmodule
